/* rtl/estm_pkg.sv */
package estm_pkg;

	// rotation order codes; the unused code behaves as X-Y-Z
	localparam logic [1:0] MODE_XYZ = 2'd0;
	localparam logic [1:0] MODE_ZYX = 2'd1;
	localparam logic [1:0] MODE_YXZ = 2'd2;

	localparam int NUM_STAGES = 7;
	localparam int ANGLE_W    = 16;
	localparam int ANGLE_EXT  = 24;	// widest supported phase
	localparam int SCALE_W    = 16;
	localparam int OFFSET_W   = 32;
	localparam int ENTRY_W    = 24;
	localparam int TRIG_W     = 18;	// signed Q16, range +-65536
	localparam int R16_W      = 19;	// rotation entry after Q48 -> Q16 rounding

	localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = 24'sh7FFFFF;
	localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = 24'sh800000;

	typedef struct packed {
		logic signed [TRIG_W-1:0] sin;
		logic signed [TRIG_W-1:0] cos;
	} trig_t;

	// per-stage load enables
	typedef struct packed {
		logic s7;
		logic s6;
		logic s5;
		logic s4;
		logic s3;
		logic s2;
		logic s1;
	} stage_en_t;

endpackage

/* rtl/estm_sine_rom.sv */
module estm_sine_rom #(
	parameter int ENTRIES = 1024,
	parameter int AW = $clog2(ENTRIES + 1)
) (
	input  logic          clk,
	input  logic          en,
	input  logic [AW-1:0] addr_a,
	input  logic [AW-1:0] addr_b,
	output logic [16:0]   data_a,
	output logic [16:0]   data_b
);

	localparam logic [63:0] PiHalfQ30 = 64'd1686629713;

	typedef logic [16:0] rom_t [0:ENTRIES];

	// quarter-wave sine, Q16, Taylor series in Q30 with truncating steps
	function automatic rom_t build_rom();
		rom_t        t;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		for (int i = 0; i <= ENTRIES; i++) begin
			x    = (PiHalfQ30 * 64'(i)) / 64'(ENTRIES);
			x2   = (x * x) >> 30;
			term = x;
			sum  = x;
			for (int k = 1; k <= 8; k++) begin
				term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
				if ((k % 2) == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			v = (sum + 64'd8192) >> 14;
			if (v > 64'd65536) begin
				v = 64'd65536;
			end
			t[i] = v[16:0];
		end
		return t;
	endfunction

	localparam rom_t ROM = build_rom();

	always_ff @(posedge clk) begin
		if (en) begin
			data_a <= ROM[addr_a];
			data_b <= ROM[addr_b];
		end
	end

endmodule

/* rtl/estm_trig.sv */
module estm_trig #(
	parameter int ANGLE_BITS = 16,
	parameter int ENTRIES = 1024
) (
	input  logic                                 clk,
	input  estm_pkg::stage_en_t                  en,
	input  logic signed [estm_pkg::ANGLE_W-1:0]  angle,
	output estm_pkg::trig_t                      trig
);

	localparam int QB = ANGLE_BITS - 2;
	localparam int AW = $clog2(ENTRIES + 1);
	localparam int PW = QB + AW;

	logic [estm_pkg::ANGLE_EXT-1:0] ext;
	logic [ANGLE_BITS-1:0]          phase;
	logic [PW-1:0]                  prod;
	logic [AW-1:0]                  idx_s1;
	logic [1:0]                     quad_s1;
	logic [AW-1:0]                  addr_sin;
	logic [AW-1:0]                  addr_cos;
	logic                           neg_sin_s2;
	logic                           neg_cos_s2;
	logic [16:0]                    mag_sin_s2;
	logic [16:0]                    mag_cos_s2;
	logic signed [estm_pkg::TRIG_W-1:0] ms;
	logic signed [estm_pkg::TRIG_W-1:0] mc;

	assign ext   = {{(estm_pkg::ANGLE_EXT - estm_pkg::ANGLE_W){angle[estm_pkg::ANGLE_W-1]}}, angle};
	assign phase = ext[ANGLE_BITS-1:0];
	assign prod  = PW'(phase[QB-1:0]) * PW'(ENTRIES);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			idx_s1  <= AW'(prod >> QB);
			quad_s1 <= phase[ANGLE_BITS-1:ANGLE_BITS-2];
		end
	end

	// odd quadrants read the table backward; cosine is one quadrant ahead
	assign addr_sin = quad_s1[0] ? (AW'(ENTRIES) - idx_s1) : idx_s1;
	assign addr_cos = quad_s1[0] ? idx_s1 : (AW'(ENTRIES) - idx_s1);

	estm_sine_rom #(.ENTRIES(ENTRIES)) u_rom (
		.clk    (clk),
		.en     (en.s2),
		.addr_a (addr_sin),
		.addr_b (addr_cos),
		.data_a (mag_sin_s2),
		.data_b (mag_cos_s2)
	);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			neg_sin_s2 <= quad_s1[1];
			neg_cos_s2 <= quad_s1[1] ^ quad_s1[0];
		end
	end

	assign ms = $signed({1'b0, mag_sin_s2});
	assign mc = $signed({1'b0, mag_cos_s2});
	assign trig.sin = neg_sin_s2 ? -ms : ms;
	assign trig.cos = neg_cos_s2 ? -mc : mc;

endmodule

/* rtl/estm_rotate.sv */
module estm_rotate (
	input  logic                                 clk,
	input  estm_pkg::stage_en_t                  en,
	input  logic [1:0]                           mode_s2,
	input  estm_pkg::trig_t                      tx,
	input  estm_pkg::trig_t                      ty,
	input  estm_pkg::trig_t                      tz,
	output logic signed [estm_pkg::R16_W-1:0]    r16_s5 [9]
);

	localparam int TW = estm_pkg::TRIG_W;

	// pair products, in order: c1c2 c2s1 c1c3 c1s3 c2c3 c2s3 c3s1 s1s3
	localparam int P_C1C2 = 0;
	localparam int P_C2S1 = 1;
	localparam int P_C1C3 = 2;
	localparam int P_C1S3 = 3;
	localparam int P_C2C3 = 4;
	localparam int P_C2S3 = 5;
	localparam int P_C3S1 = 6;
	localparam int P_S1S3 = 7;

	logic signed [TW-1:0] c1, s1, c2, s2, c3, s3;
	logic signed [TW-1:0] pa [8];
	logic signed [TW-1:0] pb [8];
	logic signed [2*TW-1:0] pm [8];

	logic signed [33:0]   pair_s3 [8];
	logic signed [TW-1:0] s2_s3;
	logic [1:0]           mode_s3;

	logic signed [51:0]   tm [4];
	logic signed [51:0]   tri_s4 [4];
	logic signed [33:0]   pair_s4 [8];
	logic signed [TW-1:0] s2_s4;
	logic [1:0]           mode_s4;

	logic signed [51:0]   pw [8];
	logic signed [51:0]   sq;
	logic signed [51:0]   r48 [9];
	logic signed [51:0]   rw [9];

	// map the angles onto first, second and third rotation
	always_comb begin
		unique case (mode_s2)
			estm_pkg::MODE_ZYX: begin
				c1 = tz.cos; s1 = tz.sin; c2 = ty.cos; s2 = ty.sin; c3 = tx.cos; s3 = tx.sin;
			end
			estm_pkg::MODE_YXZ: begin
				c1 = ty.cos; s1 = ty.sin; c2 = tx.cos; s2 = tx.sin; c3 = tz.cos; s3 = tz.sin;
			end
			default: begin
				c1 = tx.cos; s1 = tx.sin; c2 = ty.cos; s2 = ty.sin; c3 = tz.cos; s3 = tz.sin;
			end
		endcase
	end

	always_comb begin
		pa[P_C1C2] = c1; pb[P_C1C2] = c2;
		pa[P_C2S1] = c2; pb[P_C2S1] = s1;
		pa[P_C1C3] = c1; pb[P_C1C3] = c3;
		pa[P_C1S3] = c1; pb[P_C1S3] = s3;
		pa[P_C2C3] = c2; pb[P_C2C3] = c3;
		pa[P_C2S3] = c2; pb[P_C2S3] = s3;
		pa[P_C3S1] = c3; pb[P_C3S1] = s1;
		pa[P_S1S3] = s1; pb[P_S1S3] = s3;
	end

	for (genvar i = 0; i < 8; i++) begin : g_pair
		assign pm[i] = pa[i] * pb[i];
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int i = 0; i < 8; i++) begin
				pair_s3[i] <= pm[i][33:0];
			end
			s2_s3   <= s2;
			mode_s3 <= mode_s2;
		end
	end

	// triple products: s2 times c1s3, c3s1, s1s3, c1c3
	assign tm[0] = pair_s3[P_C1S3] * s2_s3;
	assign tm[1] = pair_s3[P_C3S1] * s2_s3;
	assign tm[2] = pair_s3[P_S1S3] * s2_s3;
	assign tm[3] = pair_s3[P_C1C3] * s2_s3;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			tri_s4  <= tm;
			pair_s4 <= pair_s3;
			s2_s4   <= s2_s3;
			mode_s4 <= mode_s3;
		end
	end

	// pairs scaled up to Q48
	for (genvar i = 0; i < 8; i++) begin : g_pw
		assign pw[i] = {{2{pair_s4[i][33]}}, pair_s4[i], 16'd0};
	end
	assign sq = {{2{s2_s4[TW-1]}}, s2_s4, 32'd0};

	always_comb begin
		unique case (mode_s4)
			estm_pkg::MODE_ZYX: begin
				r48[0] = pw[P_C1C2];
				r48[1] = pw[P_C2S1];
				r48[2] = -sq;
				r48[3] = tri_s4[0] - pw[P_C3S1];
				r48[4] = pw[P_C1C3] + tri_s4[2];
				r48[5] = pw[P_C2S3];
				r48[6] = pw[P_S1S3] + tri_s4[3];
				r48[7] = tri_s4[1] - pw[P_C1S3];
				r48[8] = pw[P_C2C3];
			end
			estm_pkg::MODE_YXZ: begin
				r48[0] = pw[P_C1C3] + tri_s4[2];
				r48[1] = pw[P_C2S3];
				r48[2] = tri_s4[0] - pw[P_C3S1];
				r48[3] = tri_s4[1] - pw[P_C1S3];
				r48[4] = pw[P_C2C3];
				r48[5] = tri_s4[3] + pw[P_S1S3];
				r48[6] = pw[P_C2S1];
				r48[7] = -sq;
				r48[8] = pw[P_C1C2];
			end
			default: begin
				r48[0] = pw[P_C2C3];
				r48[1] = pw[P_C1S3] + tri_s4[1];
				r48[2] = pw[P_S1S3] - tri_s4[3];
				r48[3] = -pw[P_C2S3];
				r48[4] = pw[P_C1C3] - tri_s4[2];
				r48[5] = pw[P_C3S1] + tri_s4[0];
				r48[6] = sq;
				r48[7] = -pw[P_C2S1];
				r48[8] = pw[P_C1C2];
			end
		endcase
	end

	// Q48 -> Q16, round half up
	for (genvar k = 0; k < 9; k++) begin : g_rnd
		assign rw[k] = r48[k] + (52'sd1 <<< 31);
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			for (int k = 0; k < 9; k++) begin
				r16_s5[k] <= rw[k][50:32];
			end
		end
	end

endmodule

/* rtl/euler_scale_translate_matrix.sv */
// Euler-angle / scale / translation matrix generator, fixed point.
//
// Input channel (in_valid / in_stall): rotation order, three binary angles,
// three Q8.8 scales and three Q16.16 offsets. Output channel (out_valid /
// out_stall): the scaled 3x3 rotation in column-major order as saturated
// Q8.16 entries, plus the offsets copied through. An item moves at a clock
// edge where valid is high and stall is low.
//
// An accepted item shows on out_valid once it reaches the last of the
// seven register stages and leaves at an edge with out_stall low. One
// item per cycle is sustained while out_stall is low. Stages: phase to
// table index, sine table read, pair products, triple products, sum and
// round to Q16, scale multiply, round/saturate into the output register.
//
// Each stage loads whenever it is empty or the stage after it moves, so
// bubbles close up while the receiver stalls and in_stall rises only when
// all seven stages hold an item. A stalled output item holds steady.
// Reset clears the valid bits only; the sine table is constant logic.
module euler_scale_translate_matrix #(
	parameter int ANGLE_BITS = 16,
	parameter int SINE_TABLE_ENTRIES = 1024
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             mode,
	input  logic signed [estm_pkg::ANGLE_W-1:0]    angle_x,
	input  logic signed [estm_pkg::ANGLE_W-1:0]    angle_y,
	input  logic signed [estm_pkg::ANGLE_W-1:0]    angle_z,
	input  logic signed [estm_pkg::SCALE_W-1:0]    scale_x,
	input  logic signed [estm_pkg::SCALE_W-1:0]    scale_y,
	input  logic signed [estm_pkg::SCALE_W-1:0]    scale_z,
	input  logic signed [estm_pkg::OFFSET_W-1:0]   offset_x,
	input  logic signed [estm_pkg::OFFSET_W-1:0]   offset_y,
	input  logic signed [estm_pkg::OFFSET_W-1:0]   offset_z,

	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [estm_pkg::ENTRY_W-1:0]    col0_row0,
	output logic signed [estm_pkg::ENTRY_W-1:0]    col0_row1,
	output logic signed [estm_pkg::ENTRY_W-1:0]    col0_row2,
	output logic signed [estm_pkg::ENTRY_W-1:0]    col1_row0,
	output logic signed [estm_pkg::ENTRY_W-1:0]    col1_row1,
	output logic signed [estm_pkg::ENTRY_W-1:0]    col1_row2,
	output logic signed [estm_pkg::ENTRY_W-1:0]    col2_row0,
	output logic signed [estm_pkg::ENTRY_W-1:0]    col2_row1,
	output logic signed [estm_pkg::ENTRY_W-1:0]    col2_row2,
	output logic signed [estm_pkg::OFFSET_W-1:0]   out_offset_x,
	output logic signed [estm_pkg::OFFSET_W-1:0]   out_offset_y,
	output logic signed [estm_pkg::OFFSET_W-1:0]   out_offset_z
);

	localparam int NS = estm_pkg::NUM_STAGES;
	localparam int SW = estm_pkg::SCALE_W;
	localparam int OW = estm_pkg::OFFSET_W;
	localparam int RW = estm_pkg::R16_W;
	localparam int MW = RW + SW;	// r16 * scale, exact

	// ---------------------------------------------------------------
	// Stage control: valid bit per stage, load enable chained back
	// from the output register.
	// ---------------------------------------------------------------
	logic [NS:1]         v_q;
	logic [NS:1]         en_v;
	estm_pkg::stage_en_t en;

	always_comb begin
		en_v[NS] = !v_q[NS] || !out_stall;
		for (int k = NS - 1; k >= 1; k--) begin
			en_v[k] = !v_q[k] || en_v[k+1];
		end
	end

	assign en = estm_pkg::stage_en_t'(en_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en_v[1]) begin
				v_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en_v[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign in_stall  = !en_v[1];
	assign out_valid = v_q[NS];

	// ---------------------------------------------------------------
	// Sine/cosine per axis (stages 1-2)
	// ---------------------------------------------------------------
	estm_pkg::trig_t tx, ty, tz;

	estm_trig #(.ANGLE_BITS(ANGLE_BITS), .ENTRIES(SINE_TABLE_ENTRIES)) u_trig_x (
		.clk (clk), .en (en), .angle (angle_x), .trig (tx)
	);
	estm_trig #(.ANGLE_BITS(ANGLE_BITS), .ENTRIES(SINE_TABLE_ENTRIES)) u_trig_y (
		.clk (clk), .en (en), .angle (angle_y), .trig (ty)
	);
	estm_trig #(.ANGLE_BITS(ANGLE_BITS), .ENTRIES(SINE_TABLE_ENTRIES)) u_trig_z (
		.clk (clk), .en (en), .angle (angle_z), .trig (tz)
	);

	// ---------------------------------------------------------------
	// Side payload travelling alongside: mode, scales, offsets
	// ---------------------------------------------------------------
	logic [1:0]           mode_s1, mode_s2;
	logic signed [SW-1:0] sc_s1 [3];
	logic signed [SW-1:0] sc_s2 [3];
	logic signed [SW-1:0] sc_s3 [3];
	logic signed [SW-1:0] sc_s4 [3];
	logic signed [SW-1:0] sc_s5 [3];
	logic signed [OW-1:0] off_s1 [3];
	logic signed [OW-1:0] off_s2 [3];
	logic signed [OW-1:0] off_s3 [3];
	logic signed [OW-1:0] off_s4 [3];
	logic signed [OW-1:0] off_s5 [3];
	logic signed [OW-1:0] off_s6 [3];
	logic signed [OW-1:0] off_s7 [3];

	always_ff @(posedge clk) begin
		if (en.s1) begin
			mode_s1   <= mode;
			sc_s1[0]  <= scale_x;
			sc_s1[1]  <= scale_y;
			sc_s1[2]  <= scale_z;
			off_s1[0] <= offset_x;
			off_s1[1] <= offset_y;
			off_s1[2] <= offset_z;
		end
		if (en.s2) begin
			mode_s2 <= mode_s1;
			sc_s2   <= sc_s1;
			off_s2  <= off_s1;
		end
		if (en.s3) begin
			sc_s3  <= sc_s2;
			off_s3 <= off_s2;
		end
		if (en.s4) begin
			sc_s4  <= sc_s3;
			off_s4 <= off_s3;
		end
		if (en.s5) begin
			sc_s5  <= sc_s4;
			off_s5 <= off_s4;
		end
		if (en.s6) begin
			off_s6 <= off_s5;
		end
		if (en.s7) begin
			off_s7 <= off_s6;
		end
	end

	// ---------------------------------------------------------------
	// Rotation entries in Q16 (stages 3-5)
	// ---------------------------------------------------------------
	logic signed [RW-1:0] r16_s5 [9];

	estm_rotate u_rotate (
		.clk     (clk),
		.en      (en),
		.mode_s2 (mode_s2),
		.tx      (tx),
		.ty      (ty),
		.tz      (tz),
		.r16_s5  (r16_s5)
	);

	// ---------------------------------------------------------------
	// Column scale (stage 6), round Q24 -> Q16 and saturate (stage 7)
	// ---------------------------------------------------------------
	logic signed [MW-1:0]                 prod_s6 [9];
	logic signed [MW-1:0]                 pr [9];
	logic signed [MW-1:0]                 rnd [9];
	logic signed [MW-9:0]                 q16 [9];
	logic signed [estm_pkg::ENTRY_W-1:0]  sat [9];
	logic signed [estm_pkg::ENTRY_W-1:0]  ent_s7 [9];

	for (genvar k = 0; k < 9; k++) begin : g_ent
		assign pr[k]  = r16_s5[k] * sc_s5[k / 3];
		assign rnd[k] = prod_s6[k] + MW'(128);
		assign q16[k] = rnd[k][MW-1:8];
		always_comb begin
			if (q16[k] > (MW - 8)'(estm_pkg::ENTRY_MAX)) begin
				sat[k] = estm_pkg::ENTRY_MAX;
			end else if (q16[k] < (MW - 8)'(estm_pkg::ENTRY_MIN)) begin
				sat[k] = estm_pkg::ENTRY_MIN;
			end else begin
				sat[k] = q16[k][estm_pkg::ENTRY_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			prod_s6 <= pr;
		end
		if (en.s7) begin
			ent_s7 <= sat;
		end
	end

	assign col0_row0    = ent_s7[0];
	assign col0_row1    = ent_s7[1];
	assign col0_row2    = ent_s7[2];
	assign col1_row0    = ent_s7[3];
	assign col1_row1    = ent_s7[4];
	assign col1_row2    = ent_s7[5];
	assign col2_row0    = ent_s7[6];
	assign col2_row1    = ent_s7[7];
	assign col2_row2    = ent_s7[8];
	assign out_offset_x = off_s7[0];
	assign out_offset_y = off_s7[1];
	assign out_offset_z = off_s7[2];

`ifndef SYNTHESIS
	// back-pressure only reaches the input once every stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&v_q))
		else $error("input stalled with an empty stage");

	// input stall implies a stalled result waiting at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output back-pressure");
`endif

endmodule
